### hw/rtl/seven_bit_escape_decoder_checksum_defines.svh
// assertion helpers used by the rtl
`ifndef SEVEN_BIT_ESCAPE_DECODER_CHECKSUM_DEFINES_SVH
`define SEVEN_BIT_ESCAPE_DECODER_CHECKSUM_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SBED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbed same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SBED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbed next-cycle check failed");

`endif

### hw/rtl/sbed_pkg.sv
`timescale 1ns / 1ps
package sbed_pkg;

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_MATCH    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_CORRUPT  = 2'd3
  } status_e;

  // 7-bit character codes
  localparam logic [6:0] CHAR_CR        = 7'h0d;
  localparam logic [6:0] CHAR_SPACE     = 7'o040;
  localparam logic [6:0] PREFIX_FIRST   = 7'o172;
  localparam logic [6:0] PREFIX_TRAILER = 7'o176;
  localparam logic [6:0] PREFIX_BAD     = 7'o177;

  // escape prefix codes, 1..5 stand for 0172..0176
  localparam logic [2:0] ESC_NONE = 3'd0;
  localparam logic [2:0] ESC_172  = 3'd1;
  localparam logic [2:0] ESC_173  = 3'd2;
  localparam logic [2:0] ESC_174  = 3'd3;
  localparam logic [2:0] ESC_175  = 3'd4;
  localparam logic [2:0] ESC_176  = 3'd5;

  // trailer position codes
  localparam logic [2:0] TRL_IDLE   = 3'd0;
  localparam logic [2:0] TRL_DIGIT1 = 3'd1;
  localparam logic [2:0] TRL_CR     = 3'd5;

  localparam logic [15:0] CSUM_INIT = 16'hffff;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] esc_offset(input logic [2:0] esc);
    logic [7:0] off;
    unique case (esc)
      ESC_172: off = 8'o300;  // minus 0100
      ESC_173: off = 8'o100;
      ESC_174: off = 8'o100;
      ESC_175: off = 8'o200;
      ESC_176: off = 8'o300;
      default: off = 8'o000;
    endcase
    return off;
  endfunction

  function automatic hex_t hex_decode(input logic [6:0] ch);
    hex_t h;
    h = '{ok: 1'b0, val: 4'd0};
    if (ch >= 7'h30 && ch <= 7'h39) begin
      h = '{ok: 1'b1, val: ch[3:0]};
    end else if ((ch >= 7'h41 && ch <= 7'h46) || (ch >= 7'h61 && ch <= 7'h66)) begin
      h = '{ok: 1'b1, val: 4'(ch[2:0] + 3'd1) + 4'd8};
    end
    return h;
  endfunction

endpackage

### hw/rtl/sbed_in_if.sv
`timescale 1ns / 1ps
interface sbed_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

### hw/rtl/sbed_out_if.sv
`timescale 1ns / 1ps
interface sbed_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [1:0] status;

  modport source (output valid, output data_valid, output data_byte, output status,
                  input ready);
  modport sink (input valid, input data_valid, input data_byte, input status,
                output ready);
endinterface

### hw/rtl/seven_bit_escape_decoder_checksum.sv
`timescale 1ns / 1ps
// seven-bit escape decoder with file checksum
// in_i carries one received character per word: opcode 1 starts a new file
// (decoder and checksum back to their start values), opcode 0 is a byte off
// the line whose bit 7 is ignored
// out_o gives exactly one word per input word: a decoded file byte with
// data_valid set, or an empty word whose status tells running (0), trailer
// checksum match (1), mismatch (2) or a corrupt stream (3)
// after a final status the decoder drops bytes until the next start word
// a word sits in the input register first, then the decode and checksum
// update feed the result register
// throughput is one word per cycle while out_o does not stall, set by the single decode step between
// the input register and the result register
// a stall on out_o holds the result register, the input register then
// fills and ready on in_i drops once both are full
// reset empties both registers and sets the checksum to 0xffff
module seven_bit_escape_decoder_checksum import sbed_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  sbed_in_if.sink     in_i,
  sbed_out_if.source  out_o
);

`include "seven_bit_escape_decoder_checksum_defines.svh"

  // input register
  logic  s1_valid_q;
  item_t s1_item_q;

  // result register
  logic  out_valid_q;
  res_t  out_res_q;

  res_t  core_res;
  logic  out_free;   // result register can take a new word this cycle
  logic  step;       // word moves from input register through the decoder
  logic  in_take;

  assign out_free  = !out_valid_q || out_o.ready;
  assign step      = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take   = in_i.valid && in_i.ready;

  // decoder state only moves when a word actually steps into the result register
  sbed_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{opcode: in_i.opcode, rx_byte: in_i.rx_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_valid = out_res_q.data_valid;
  assign out_o.data_byte  = out_res_q.data_byte;
  assign out_o.status     = out_res_q.status;

  // a decoded byte never carries a final status, an empty word has no data
  `SBED_ASSERT_NOW(a_data_running, out_valid_q && out_res_q.data_valid,
    out_res_q.status == ST_RUN)
  `SBED_ASSERT_NOW(a_empty_zero, out_valid_q && !out_res_q.data_valid,
    out_res_q.data_byte == 8'd0)
  // every decode step lands in the result register
  `SBED_ASSERT_NEXT(a_step_lands, step, out_valid_q)
  // a word in the input register is never lost while the output stalls
  `SBED_ASSERT_NEXT(a_s1_holds, s1_valid_q && !out_free, s1_valid_q)

endmodule

### hw/rtl/sbed_core.sv
`timescale 1ns / 1ps
module sbed_core import sbed_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  output res_t  res_o
);

  logic [2:0]  esc_q, esc_d;
  logic [2:0]  trl_q, trl_d;
  logic [15:0] rcv_q, rcv_d;
  logic [15:0] run_q, run_d;
  logic        stop_q, stop_d;

  logic [6:0] ch;
  logic [7:0] dec;
  hex_t       hex;

  assign ch  = item_i.rx_byte[6:0];
  assign dec = {1'b0, ch} + esc_offset(esc_q);
  assign hex = hex_decode(ch);

  always_comb begin
    esc_d  = esc_q;
    trl_d  = trl_q;
    rcv_d  = rcv_q;
    run_d  = run_q;
    stop_d = stop_q;
    res_o  = '{data_valid: 1'b0, data_byte: 8'd0, status: ST_RUN};
    if (item_i.opcode) begin
      esc_d  = ESC_NONE;
      trl_d  = TRL_IDLE;
      rcv_d  = 16'd0;
      run_d  = CSUM_INIT;
      stop_d = 1'b0;
    end else if (!stop_q) begin
      if (trl_q != TRL_IDLE) begin
        if (trl_q != TRL_CR) begin
          if (hex.ok) begin
            rcv_d = {rcv_q[11:0], hex.val};
            trl_d = trl_q + 3'd1;
          end else begin
            stop_d       = 1'b1;
            res_o.status = ST_CORRUPT;
          end
        end else begin
          stop_d = 1'b1;
          priority if (ch != CHAR_CR) begin
            res_o.status = ST_CORRUPT;
          end else if (rcv_q == run_q) begin
            res_o.status = ST_MATCH;
          end else begin
            res_o.status = ST_MISMATCH;
          end
        end
      end else if (ch >= PREFIX_FIRST) begin
        priority if (esc_q != ESC_NONE) begin
          esc_d = ESC_NONE;
          if (ch == PREFIX_TRAILER) begin
            trl_d = TRL_DIGIT1;
            rcv_d = 16'd0;
          end else begin
            stop_d       = 1'b1;
            res_o.status = ST_CORRUPT;
          end
        end else if (ch == PREFIX_BAD) begin
          stop_d       = 1'b1;
          res_o.status = ST_CORRUPT;
        end else begin
          esc_d = ch[2:0] - 3'd1;
        end
      end else if (ch < CHAR_SPACE) begin
        stop_d       = 1'b1;
        res_o.status = ST_CORRUPT;
      end else begin
        esc_d            = ESC_NONE;
        run_d            = {run_q[14:0], run_q[15]} + {8'd0, dec};
        res_o.data_valid = 1'b1;
        res_o.data_byte  = dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= ESC_NONE;
      trl_q  <= TRL_IDLE;
      rcv_q  <= 16'd0;
      run_q  <= CSUM_INIT;
      stop_q <= 1'b0;
    end else if (step_i) begin
      esc_q  <= esc_d;
      trl_q  <= trl_d;
      rcv_q  <= rcv_d;
      run_q  <= run_d;
      stop_q <= stop_d;
    end
  end

endmodule
